@@ rtl/core/vblank_pacing_timer_core_macros.svh @@
// assertion macros for the vblank pacing timer checker
// used by the checker file only, no other dependencies
`ifndef VBLANK_PACING_TIMER_CORE_MACROS_SVH
`define VBLANK_PACING_TIMER_CORE_MACROS_SVH

// property checked while out of reset
`define VPT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("vpt assertion failed");

// property checked on every edge, reset included
`define VPT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("vpt reset check failed");

`endif

@@ rtl/core/vpt_pkg.sv @@
// shared types and constants for the vblank pacing timer
// no dependencies
package vpt_pkg;

    localparam int unsigned WORD_W    = 64;
    localparam int unsigned HALF_W    = 32;
    localparam int unsigned CFG_IDX_W = 8;

    typedef logic [WORD_W-1:0]    t_word;
    typedef logic [HALF_W-1:0]    t_half;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_NUMERATOR   = 8'd0;
    localparam t_cfg_idx CFG_DENOMINATOR = 8'd1;

    localparam t_half NS_PER_SECOND     = 32'd1000000000;
    localparam t_word DEFAULT_PERIOD_NS = 64'd16666666;

endpackage

@@ rtl/core/vpt_channels.sv @@
// valid/ready channel interfaces for the vblank pacing timer
// depends on vpt_pkg
interface vpt_req_if;
    logic          valid;
    logic          ready;
    vpt_pkg::t_word now_time;
    modport source (output valid, output now_time, input ready);
    modport sink   (input valid, input now_time, output ready);
endinterface

interface vpt_wake_if;
    logic          valid;
    logic          ready;
    vpt_pkg::t_word wake_time;
    logic          paced;
    modport source (output valid, output wake_time, output paced, input ready);
    modport sink   (input valid, input wake_time, input paced, output ready);
endinterface

interface vpt_cfg_if;
    logic             valid;
    logic             ready;
    vpt_pkg::t_cfg_idx index;
    vpt_pkg::t_half    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/vblank_pacing_timer_core.sv @@
// vblank pacing timer: next frame boundary from a phase anchor and refresh rate
// depends on vpt_pkg and the channel interfaces in vpt_channels.sv
// states per request with both rate registers set: S_PMUL, S_DIV, S_ANCH, S_DIV again,
//   S_MUL0 to S_MUL2, S_DONE; 60 Hz default starts at S_ANCH, zero period jumps to S_DONE
// a new request is taken only in S_IDLE; S_DONE waits until the output register is free
// reset (synchronous, active low): rates zero, anchor cleared, no result pending
module vblank_pacing_timer_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    vpt_req_if.sink           i_req,
    vpt_wake_if.source        o_wake,
    vpt_cfg_if.sink           i_cfg
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PMUL = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_ANCH = 3'd3;
    localparam logic [2:0] S_MUL0 = 3'd4;
    localparam logic [2:0] S_MUL1 = 3'd5;
    localparam logic [2:0] S_MUL2 = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    localparam int unsigned CNT_W = $clog2(vpt_pkg::WORD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(vpt_pkg::WORD_W - 1);

    logic [2:0]       r_state, n_state;
    vpt_pkg::t_half   r_num, r_den;
    vpt_pkg::t_word   r_anchor, n_anchor;
    vpt_pkg::t_word   r_now;
    vpt_pkg::t_word   r_period, n_period;
    vpt_pkg::t_word   r_base, n_base;
    vpt_pkg::t_word   r_mula, n_mula;
    vpt_pkg::t_word   r_acc, n_acc;
    vpt_pkg::t_word   r_dvd, n_dvd;
    vpt_pkg::t_word   r_rem, n_rem;
    vpt_pkg::t_word   r_dvs, n_dvs;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_pass, n_pass;
    logic             r_paced, n_paced;
    logic             r_out_valid, n_out_valid;
    vpt_pkg::t_word   r_out_wake, n_out_wake;
    logic             r_out_paced, n_out_paced;

    logic                    req_fire;
    logic                    out_free;
    logic [vpt_pkg::WORD_W:0] div_sh;
    logic [vpt_pkg::WORD_W:0] div_diff;
    logic                    div_ge;
    vpt_pkg::t_half          mul_a, mul_b;
    vpt_pkg::t_word          mul_p;
    vpt_pkg::t_word          anch_sel;
    vpt_pkg::t_word          boundary;

    assign i_req.ready     = (r_state == S_IDLE);
    assign i_cfg.ready     = 1'b1;
    assign o_wake.valid    = r_out_valid;
    assign o_wake.wake_time = r_out_wake;
    assign o_wake.paced    = r_out_paced;

    assign req_fire = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_wake.ready;

    // shared restoring divider step
    assign div_sh   = {r_rem, r_dvd[vpt_pkg::WORD_W-1]};
    assign div_diff = div_sh - {1'b0, r_dvs};
    assign div_ge   = (div_sh >= {1'b0, r_dvs});

    // shared 32x32 multiplier
    always_comb begin
        case (r_state)
            S_PMUL: begin
                mul_a = vpt_pkg::NS_PER_SECOND;
                mul_b = r_den;
            end
            S_MUL1: begin
                mul_a = r_mula[vpt_pkg::HALF_W-1:0];
                mul_b = r_period[vpt_pkg::WORD_W-1:vpt_pkg::HALF_W];
            end
            S_MUL2: begin
                mul_a = r_mula[vpt_pkg::WORD_W-1:vpt_pkg::HALF_W];
                mul_b = r_period[vpt_pkg::HALF_W-1:0];
            end
            default: begin
                mul_a = r_mula[vpt_pkg::HALF_W-1:0];
                mul_b = r_period[vpt_pkg::HALF_W-1:0];
            end
        endcase
    end
    assign mul_p = vpt_pkg::WORD_W'(mul_a) * vpt_pkg::WORD_W'(mul_b);

    // unanchored: start from now, or 1 when now is zero
    assign anch_sel = (r_anchor != '0) ? r_anchor :
                      ((r_now != '0) ? r_now : vpt_pkg::WORD_W'(1));
    assign boundary = r_base + r_acc;

    always_comb begin
        n_state     = r_state;
        n_anchor    = r_anchor;
        n_period    = r_period;
        n_base      = r_base;
        n_mula      = r_mula;
        n_acc       = r_acc;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_dvs       = r_dvs;
        n_cnt       = r_cnt;
        n_pass      = r_pass;
        n_paced     = r_paced;
        n_out_valid = r_out_valid;
        n_out_wake  = r_out_wake;
        n_out_paced = r_out_paced;

        if (r_out_valid && o_wake.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    if (r_num == '0 || r_den == '0) begin
                        n_period = vpt_pkg::DEFAULT_PERIOD_NS;
                        n_state  = S_ANCH;
                    end else begin
                        n_state  = S_PMUL;
                    end
                end
            end
            S_PMUL: begin
                n_dvd   = mul_p;
                n_rem   = '0;
                n_dvs   = vpt_pkg::WORD_W'(r_num);
                n_cnt   = '0;
                n_pass  = 1'b0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = div_ge ? div_diff[vpt_pkg::WORD_W-1:0]
                               : div_sh[vpt_pkg::WORD_W-1:0];
                n_dvd = {r_dvd[vpt_pkg::WORD_W-2:0], div_ge};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    if (!r_pass) begin
                        n_period = n_dvd;
                        n_state  = S_ANCH;
                    end else begin
                        n_mula   = n_dvd + vpt_pkg::WORD_W'(1);
                        n_state  = S_MUL0;
                    end
                end
            end
            S_ANCH: begin
                if (r_period == '0) begin
                    n_paced = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_paced = 1'b1;
                    n_base  = anch_sel;
                    n_dvd   = (r_now > anch_sel) ? (r_now - anch_sel) : '0;
                    n_rem   = '0;
                    n_dvs   = r_period;
                    n_cnt   = '0;
                    n_pass  = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_MUL0: begin
                n_acc   = mul_p;
                n_state = S_MUL1;
            end
            // cross terms only touch the upper half of the wrapped product
            S_MUL1: begin
                n_acc   = r_acc + {mul_p[vpt_pkg::HALF_W-1:0], vpt_pkg::HALF_W'(0)};
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_acc   = r_acc + {mul_p[vpt_pkg::HALF_W-1:0], vpt_pkg::HALF_W'(0)};
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_paced = r_paced;
                    n_out_wake  = r_paced ? boundary : r_now;
                    if (r_paced) begin
                        n_anchor = boundary;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_num       <= '0;
            r_den       <= '0;
            r_anchor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_anchor    <= n_anchor;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    vpt_pkg::CFG_NUMERATOR:   r_num <= i_cfg.data;
                    vpt_pkg::CFG_DENOMINATOR: r_den <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_now <= i_req.now_time;
        end
        r_period    <= n_period;
        r_base      <= n_base;
        r_mula      <= n_mula;
        r_acc       <= n_acc;
        r_dvd       <= n_dvd;
        r_rem       <= n_rem;
        r_dvs       <= n_dvs;
        r_cnt       <= n_cnt;
        r_pass      <= n_pass;
        r_paced     <= n_paced;
        r_out_wake  <= n_out_wake;
        r_out_paced <= n_out_paced;
    end

endmodule

@@ rtl/core/vpt_checker.sv @@
// port-level assertions for the vblank pacing timer, bound to the top level
// depends on vpt_pkg and vblank_pacing_timer_core_macros.svh
`include "vblank_pacing_timer_core_macros.svh"

module vpt_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_req_valid,
    input logic           i_req_ready,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input vpt_pkg::t_word i_wake_time,
    input logic           i_paced
);

    // a stalled result holds
    `VPT_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_wake_time) && $stable(i_paced)))
    // busy once a request is taken
    `VPT_ASSERT(a_busy_after_req, i_clk, i_rst_n, (i_req_valid && i_req_ready) |=> !i_req_ready)
    // no result can appear right after a request
    `VPT_ASSERT(a_no_instant_result, i_clk, i_rst_n, (i_req_valid && i_req_ready) |=> !$rose(i_out_valid))
    // reset leaves the block idle with nothing pending
    `VPT_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (i_req_ready && !i_out_valid))

endmodule

bind vblank_pacing_timer_core vpt_checker u_vpt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_out_valid (o_wake.valid),
    .i_out_ready (o_wake.ready),
    .i_wake_time (o_wake.wake_time),
    .i_paced     (o_wake.paced)
);

@@ bench/tb_top.sv @@
// self-checking bench for vblank_pacing_timer_core: a directed table, then random rate phases
// each wake result is predicted from a local copy of the rate registers and the phase anchor,
// or taken from the table for fixed rows; depends on vpt_pkg, vpt_channels.sv and vblank_pacing_timer_core.sv
`timescale 1ns / 1ps

module tb_top;
    import vpt_pkg::*;

    localparam int unsigned HOLD_CYCLES  = 800;
    localparam int unsigned DRAIN_CYCLES = 150;
    localparam int unsigned PHASES       = 10;
    localparam int unsigned PHASE_ITEMS  = 95;
    localparam int unsigned HOLD_AFTER   = 120;

    localparam t_cfg_idx CFG_SPARE_LO = 8'd2;
    localparam t_cfg_idx CFG_SPARE_HI = 8'hFF;
    localparam t_word    WORD_MAX     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam t_half    HALF_MAX     = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {ROW_CFG, ROW_REQ, ROW_REQ_FIXED} t_row_kind;

    typedef enum logic [2:0] {
        RATE_DEFAULT, RATE_DISPLAY, RATE_ANY, RATE_ZERO, RATE_EXTREME, RATE_TINY, RATE_DEN_ZERO
    } t_rate_mix;

    typedef struct packed {
        t_word wake_time;
        logic  paced;
    } t_wake;

    typedef struct packed {
        t_row_kind kind;
        t_cfg_idx  idx;
        t_half     value;
        t_word     now;
        t_word     wake;
        logic      paced;
    } t_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    vpt_req_if  req_ch ();
    vpt_wake_if wake_ch ();
    vpt_cfg_if  cfg_ch ();

    vblank_pacing_timer_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_wake  (wake_ch),
        .i_cfg   (cfg_ch)
    );

    always #2 i_clk = ~i_clk;

    // local view of the block
    t_half rate_num  = '0;
    t_half rate_den  = '0;
    t_word anchor_ns = '0;

    t_wake wake_q[$];
    t_row  dir_rows[$];
    int    mismatch_cnt = 0;
    int    wakes_seen   = 0;
    bit    hold_done    = 1'b0;
    bit    send_burst   = 1'b0;
    t_word clock_ns     = '0;

    function automatic t_word frame_period();
        if (rate_num == '0 || rate_den == '0) return DEFAULT_PERIOD_NS;
        return ({32'd0, NS_PER_SECOND} * {32'd0, rate_den}) / {32'd0, rate_num};
    endfunction

    function automatic t_wake predict_wake(t_word now);
        t_word per;
        t_word base;
        t_word elapsed;
        t_word boundary;
        t_wake w;
        per = frame_period();
        if (per == '0) begin
            // zero period: echo now, anchor untouched
            w.wake_time = now;
            w.paced     = 1'b0;
            return w;
        end
        base = anchor_ns;
        if (base == '0) base = (now != '0) ? now : 64'd1;
        elapsed   = (now > base) ? now - base : '0;
        boundary  = base + (elapsed / per + 64'd1) * per;
        anchor_ns = boundary;
        w.wake_time = boundary;
        w.paced     = 1'b1;
        return w;
    endfunction

    function automatic void apply_cfg(t_cfg_idx idx, t_half value);
        case (idx)
            CFG_NUMERATOR: begin
                rate_num = value;
            end
            CFG_DENOMINATOR: begin
                rate_den = value;
            end
            default: begin
            end
        endcase
    endfunction

    task automatic offer_req(t_word now, t_wake fixed, bit use_fixed);
        int unsigned gap;
        t_wake w;
        gap = send_burst ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 31) == 0) send_burst = ~send_burst;
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.now_time <= now;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        w = predict_wake(now);
        wake_q.push_back(use_fixed ? fixed : w);
    endtask

    // drop the request line and let every outstanding wake come back
    task automatic quiesce();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (wake_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, t_half value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        apply_cfg(idx, value);
        @(posedge i_clk);
    endtask

    task automatic pick_rates();
        t_half num;
        t_half den;
        t_rate_mix mix;
        mix = t_rate_mix'($urandom_range(0, 6));
        case (mix)
            RATE_DEFAULT: begin
                num = '0;
                den = $urandom;
            end
            RATE_DISPLAY: begin
                num = $urandom_range(240000, 23000);
                den = $urandom_range(1001, 1000);
            end
            RATE_ZERO: begin
                // numerator above 1e9 * denominator
                den = $urandom_range(1, 4);
                num = $urandom_range(HALF_MAX, den * NS_PER_SECOND + 32'd1);
            end
            RATE_EXTREME: begin
                num = $urandom_range(0, 1) ? HALF_MAX : 32'd1;
                den = $urandom_range(0, 1) ? HALF_MAX : 32'd1;
            end
            RATE_TINY: begin
                num = $urandom_range(NS_PER_SECOND, NS_PER_SECOND / 10);
                den = 32'd1;
            end
            RATE_DEN_ZERO: begin
                num = $urandom;
                den = '0;
            end
            default: begin
                num = $urandom;
                den = $urandom;
            end
        endcase
        write_reg(CFG_NUMERATOR, num);
        write_reg(CFG_DENOMINATOR, den);
        if ($urandom_range(0, 3) == 0)
            write_reg(t_cfg_idx'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), $urandom);
    endtask

    // mostly requests that walk forward a few frames at a time
    task automatic offer_random_req();
        t_word per;
        t_word now;
        t_word span;
        int unsigned pick;
        per  = frame_period();
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            span = (per == '0) ? t_word'($urandom) : {$urandom, $urandom} % (per * 3 + 64'd1);
            clock_ns = clock_ns + span;
            now = clock_ns;
        end else if (pick < 80) begin
            now = clock_ns - t_word'($urandom_range(0, 1000));
        end else if (pick < 90) begin
            clock_ns = {$urandom, $urandom};
            now = clock_ns;
        end else if (pick < 95) begin
            clock_ns = WORD_MAX - t_word'($urandom_range(0, 2000));
            now = clock_ns;
        end else begin
            now = '0;
        end
        offer_req(now, '0, 1'b0);
    endtask

    always @(posedge i_clk) begin
        t_wake w;
        if (i_rst_n && wake_ch.valid && wake_ch.ready) begin
            if (wake_q.size() == 0) begin
                $error("unexpected wake result: wake_time %0h paced %0b",
                       wake_ch.wake_time, wake_ch.paced);
                mismatch_cnt++;
            end else begin
                w = wake_q.pop_front();
                if (w.wake_time !== wake_ch.wake_time) begin
                    $error("wake_time: expected %0h, got %0h", w.wake_time, wake_ch.wake_time);
                    mismatch_cnt++;
                end
                if (w.paced !== wake_ch.paced) begin
                    $error("paced: expected %0b, got %0b", w.paced, wake_ch.paced);
                    mismatch_cnt++;
                end
                wakes_seen++;
            end
        end
    end

    // result side, with one long hold-off so the block backs up
    initial begin
        int unsigned stall;
        bit recv_burst;
        recv_burst = 1'b0;
        wake_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!hold_done && wakes_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                wake_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            stall = recv_burst ? 0 : $urandom_range(0, 7);
            if ($urandom_range(0, 31) == 0) recv_burst = ~recv_burst;
            if (stall != 0) begin
                wake_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            wake_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!wake_ch.valid) @(posedge i_clk);
        end
    end

    initial begin
        req_ch.valid    <= 1'b0;
        req_ch.now_time <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= CFG_NUMERATOR;
        cfg_ch.data     <= '0;
        i_rst_n         <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // kind, index, data, now, wake, paced
        dir_rows.push_back(t_row'{ROW_REQ_FIXED, CFG_NUMERATOR, '0, 64'd0, 64'd16666667, 1'b1});
        dir_rows.push_back(t_row'{ROW_REQ_FIXED, CFG_NUMERATOR, '0, 64'd16666667,
                                  64'd33333333, 1'b1});
        dir_rows.push_back(t_row'{ROW_REQ_FIXED, CFG_NUMERATOR, '0, 64'd100, 64'd49999999, 1'b1});
        dir_rows.push_back(t_row'{ROW_REQ, CFG_NUMERATOR, '0, WORD_MAX, '0, 1'b0});
        dir_rows.push_back(t_row'{ROW_CFG, CFG_NUMERATOR, NS_PER_SECOND, '0, '0, 1'b0});
        dir_rows.push_back(t_row'{ROW_CFG, CFG_DENOMINATOR, 32'd1, '0, '0, 1'b0});
        // one ns period: the boundary after the top of the range wraps to zero
        dir_rows.push_back(t_row'{ROW_REQ_FIXED, CFG_NUMERATOR, '0, WORD_MAX, 64'd0, 1'b1});
        dir_rows.push_back(t_row'{ROW_REQ_FIXED, CFG_NUMERATOR, '0, 64'd5, 64'd6, 1'b1});
        dir_rows.push_back(t_row'{ROW_REQ_FIXED, CFG_NUMERATOR, '0, 64'd0, 64'd7, 1'b1});
        dir_rows.push_back(t_row'{ROW_CFG, CFG_NUMERATOR, HALF_MAX, '0, '0, 1'b0});
        dir_rows.push_back(t_row'{ROW_REQ_FIXED, CFG_NUMERATOR, '0, 64'd12345, 64'd12345, 1'b0});
        dir_rows.push_back(t_row'{ROW_REQ_FIXED, CFG_NUMERATOR, '0, 64'd0, 64'd0, 1'b0});
        dir_rows.push_back(t_row'{ROW_REQ_FIXED, CFG_NUMERATOR, '0, WORD_MAX, WORD_MAX, 1'b0});
        dir_rows.push_back(t_row'{ROW_CFG, CFG_DENOMINATOR, HALF_MAX, '0, '0, 1'b0});
        dir_rows.push_back(t_row'{ROW_REQ_FIXED, CFG_NUMERATOR, '0, 64'd7, 64'd1000000007, 1'b1});
        dir_rows.push_back(t_row'{ROW_CFG, CFG_NUMERATOR, 32'd1, '0, '0, 1'b0});
        dir_rows.push_back(t_row'{ROW_REQ, CFG_NUMERATOR, '0, 64'h8000_0000_0000_0000, '0, 1'b0});
        dir_rows.push_back(t_row'{ROW_REQ, CFG_NUMERATOR, '0, WORD_MAX, '0, 1'b0});
        dir_rows.push_back(t_row'{ROW_CFG, CFG_SPARE_LO, '0, '0, '0, 1'b0});
        dir_rows.push_back(t_row'{ROW_CFG, CFG_SPARE_HI, HALF_MAX, '0, '0, 1'b0});
        dir_rows.push_back(t_row'{ROW_REQ, CFG_NUMERATOR, '0, 64'd123, '0, 1'b0});
        dir_rows.push_back(t_row'{ROW_CFG, CFG_NUMERATOR, '0, '0, '0, 1'b0});
        dir_rows.push_back(t_row'{ROW_REQ, CFG_NUMERATOR, '0, 64'd0, '0, 1'b0});
        dir_rows.push_back(t_row'{ROW_REQ, CFG_NUMERATOR, '0, 64'd1000000000, '0, 1'b0});
        dir_rows.push_back(t_row'{ROW_CFG, CFG_DENOMINATOR, '0, '0, '0, 1'b0});

        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                ROW_CFG: begin
                    quiesce();
                    write_reg(dir_rows[i].idx, dir_rows[i].value);
                end
                ROW_REQ_FIXED: begin
                    offer_req(dir_rows[i].now,
                              t_wake'{dir_rows[i].wake, dir_rows[i].paced}, 1'b1);
                end
                default: begin
                    offer_req(dir_rows[i].now, '0, 1'b0);
                end
            endcase
        end

        for (int p = 0; p < PHASES; p++) begin
            quiesce();
            pick_rates();
            clock_ns = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : anchor_ns;
            repeat (PHASE_ITEMS) offer_random_req();
        end

        quiesce();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #3000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
